// ===== sv/csv_pkg.sv =====
// shared types, constants and register codes for the csv field splitter
// no dependencies; csv_cfg, csv_ctrl, csv_dp and the top level import this package
package csv_pkg;

    localparam int FIELD_CAP     = 1024;
    localparam int MAX_DELIM_LEN = 4;
    localparam int MAX_NULL_LEN  = 8;
    localparam int MAX_RESULTS   = 8;

    // replay queue never holds more than one delimiter's worth of bytes
    localparam int QDEPTH = MAX_DELIM_LEN;
    localparam int QW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int DW     = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;
    localparam int DCW    = $clog2(MAX_DELIM_LEN + 1);
    localparam int RCW    = $clog2(MAX_RESULTS + 1);

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        REG_DELIM_BYTES  = 3'd0,
        REG_DELIM_LENGTH = 3'd1,
        REG_QUOTE_CHAR   = 3'd2,
        REG_ESCAPE_CHAR  = 3'd3,
        REG_NULL_MARKER  = 3'd4,
        REG_NULL_LENGTH  = 3'd5,
        REG_FIELD_LIMIT  = 3'd6,
        REG_IGNORE_EXTRA = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EXTRA   = 2'd1;
    localparam logic [1:0] STATUS_UNTERM  = 2'd2;

    // clamped configuration as seen by the datapath
    typedef struct packed {
        logic [31:0] delimiter_bytes;
        logic [2:0]  delim_len;
        byte_t       quote_char;
        byte_t       escape_char;
        logic [63:0] null_marker;
        logic [3:0]  null_length;
        logic [10:0] field_limit;
        logic        ignore_extra;
    } cfg_t;

    typedef struct packed {
        byte_t       out_byte;
        logic        byte_valid;
        logic        field_end;
        logic        field_is_null;
        logic [9:0]  field_index;
        logic        line_end;
        logic [10:0] field_count;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LOAD = 3'd1,
        OP_STEP = 3'd2,
        OP_ESC  = 3'd3,
        OP_LINE = 3'd4,
        OP_DONE = 3'd5
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic q_empty;
        logic discarding;
        logic flush;
        logic stall;
    } dp_stat_t;

endpackage

// ===== sv/csv_in_if.sv =====
// input channel: one raw byte or an end-of-line mark per word
// depends on nothing
interface csv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_line;

    modport source  (output valid, output in_byte, output end_of_line, input ready);
    modport sink    (input valid, input in_byte, input end_of_line, output ready);
    modport monitor (input valid, input in_byte, input end_of_line, input ready);
endinterface

// ===== sv/csv_out_if.sv =====
// output channel: one decoded result per word
// depends on nothing
interface csv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        field_end;
    logic        field_is_null;
    logic [9:0]  field_index;
    logic        line_end;
    logic [10:0] field_count;
    logic [1:0]  status;
    logic        last;

    modport source  (output valid, output out_byte, output byte_valid, output field_end,
                     output field_is_null, output field_index, output line_end,
                     output field_count, output status, output last, input ready);
    modport sink    (input valid, input out_byte, input byte_valid, input field_end,
                     input field_is_null, input field_index, input line_end,
                     input field_count, input status, input last, output ready);
    modport monitor (input valid, input out_byte, input byte_valid, input field_end,
                     input field_is_null, input field_index, input line_end,
                     input field_count, input status, input last, input ready);
endinterface

// ===== sv/csv_cfg.sv =====
// configuration registers with range clamping
// depends on csv_pkg
module csv_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [2:0]        index,
    input  logic [63:0]       data,
    output csv_pkg::cfg_t     cfg
);
    import csv_pkg::*;

    logic [31:0] delim_bytes_reg;
    logic [2:0]  delim_len_reg;
    byte_t       quote_reg;
    byte_t       escape_reg;
    logic [63:0] null_marker_reg;
    logic [3:0]  null_len_reg;
    logic [10:0] limit_reg;
    logic        ignore_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= 32'd44;
            delim_len_reg   <= 3'd1;
            quote_reg       <= 8'd34;
            escape_reg      <= 8'd34;
            null_marker_reg <= 64'd0;
            null_len_reg    <= 4'd0;
            limit_reg       <= 11'(FIELD_CAP);
            ignore_reg      <= 1'b0;
        end
        else if (we)
        begin
            unique case (cfg_reg_t'(index))
                REG_DELIM_BYTES:  delim_bytes_reg <= data[31:0];
                REG_DELIM_LENGTH: delim_len_reg   <= data[2:0];
                REG_QUOTE_CHAR:   quote_reg       <= data[7:0];
                REG_ESCAPE_CHAR:  escape_reg      <= data[7:0];
                REG_NULL_MARKER:  null_marker_reg <= data;
                REG_NULL_LENGTH:  null_len_reg    <= data[3:0];
                REG_FIELD_LIMIT:  limit_reg       <= data[10:0];
                REG_IGNORE_EXTRA: ignore_reg      <= data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.delimiter_bytes = delim_bytes_reg;
        cfg.quote_char      = quote_reg;
        cfg.escape_char     = escape_reg;
        cfg.null_marker     = null_marker_reg;
        cfg.null_length     = null_len_reg;
        cfg.ignore_extra    = ignore_reg;
        if (delim_len_reg == 3'd0)
            cfg.delim_len = 3'd1;
        else if (delim_len_reg > 3'(MAX_DELIM_LEN))
            cfg.delim_len = 3'(MAX_DELIM_LEN);
        else
            cfg.delim_len = delim_len_reg;
        if (limit_reg == 11'd0)
            cfg.field_limit = 11'd1;
        else if (limit_reg > 11'(FIELD_CAP))
            cfg.field_limit = 11'(FIELD_CAP);
        else
            cfg.field_limit = limit_reg;
    end

endmodule

// ===== sv/csv_ctrl.sv =====
// sequencer: accepts a word, walks the replay queue, closes the line
// depends on csv_pkg
module csv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_eol,
    output logic              in_ready,
    input  csv_pkg::dp_stat_t stat,
    output csv_pkg::dp_cmd_t  cmd
);
    import csv_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_ESC  = 5'b00100,
        S_LINE = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (stat.discarding)
                        state_next = in_eol ? S_LINE : S_DONE;
                    else
                        state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.q_empty || stat.discarding)
                    state_next = stat.flush ? S_ESC : S_DONE;
                else
                    cmd.op = OP_STEP;
            end
            S_ESC:
            begin
                cmd.op = OP_ESC;
                if (!stat.stall)
                    state_next = S_LINE;
            end
            S_LINE:
            begin
                cmd.op = OP_LINE;
                if (!stat.stall)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op = OP_DONE;
                if (!stat.stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/csv_dp.sv =====
// datapath: parse state, replay queue, delimiter window, result holding and output registers
// depends on csv_pkg
module csv_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  csv_pkg::cfg_t     cfg,
    input  csv_pkg::dp_cmd_t  cmd,
    input  csv_pkg::byte_t    in_byte,
    input  logic              in_eol,
    output csv_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output csv_pkg::result_t  out_res
);
    import csv_pkg::*;

    byte_t          q_reg   [QDEPTH];
    byte_t          q_next  [QDEPTH];
    logic [QCW-1:0] q_cnt_reg, q_cnt_next;
    logic           flush_reg, flush_next;
    byte_t          win_reg  [MAX_DELIM_LEN];
    byte_t          win_next [MAX_DELIM_LEN];
    logic [DW-1:0]  held_reg, held_next;
    logic           in_quote_reg, in_quote_next;
    logic           quote_seen_reg, quote_seen_next;
    logic           esc_held_reg, esc_held_next;
    logic           null_match_reg, null_match_next;
    logic [3:0]     raw_len_reg, raw_len_next;
    logic           discard_reg, discard_next;
    logic [1:0]     err_reg, err_next;
    logic [10:0]    field_reg, field_next;
    logic [RCW-1:0] res_cnt_reg, res_cnt_next;
    logic           pend_v_reg, pend_v_next;
    result_t        pend_reg, pend_next;
    logic           out_v_reg, out_v_next;
    result_t        out_reg, out_next;

    byte_t          x, pr, null_byte;
    byte_t          win_new [MAX_DELIM_LEN];
    byte_t          q_pop   [QDEPTH];
    byte_t          q_rb    [QDEPTH];
    logic [DCW-1:0] hn;
    logic           dmatch, keep, null_now;
    logic           emit_v, emit_take, out_free, stall, out_load;
    result_t        emit_r;
    logic [10:0]    field_inc;
    int             k;

    function automatic result_t mk_data(byte_t b, logic [9:0] idx);
        result_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.field_index = idx;
        return r;
    endfunction

    // scan helpers
    always_comb
    begin
        x       = q_reg[0];
        win_new = win_reg;
        win_new[held_reg] = x;
        hn      = DCW'(held_reg) + DCW'(1);
        dmatch  = (hn <= DCW'(cfg.delim_len));
        for (int i = 0; i < MAX_DELIM_LEN; i++)
        begin
            if (DCW'(i) < hn && win_new[i] != cfg.delimiter_bytes[8*i +: 8])
                dmatch = 1'b0;
        end
        pr        = flush_reg ? x : win_new[0];
        null_byte = cfg.null_marker[{raw_len_reg[2:0], 3'b000} +: 8];
        keep      = (raw_len_reg < cfg.null_length) && (raw_len_reg < 4'(MAX_NULL_LEN))
                    && (pr == null_byte);
        null_now  = !quote_seen_reg && null_match_reg && (raw_len_reg == cfg.null_length);
        field_inc = field_reg + 11'd1;

        q_pop = q_reg;
        for (int j = 0; j < QDEPTH - 1; j++)
            q_pop[j] = q_reg[j+1];

        // broken partial match: held bytes after the first, and the current byte, go back ahead of the queue
        for (int j = 0; j < QDEPTH; j++)
        begin
            k = j - int'(held_reg) + 1;
            if (j < int'(held_reg))
                q_rb[j] = win_new[DW'(j + 1)];
            else if (k >= 0 && k < QDEPTH)
                q_rb[j] = q_reg[QW'(k)];
            else
                q_rb[j] = 8'h00;
        end
    end

    always_comb
    begin
        q_next          = q_reg;
        q_cnt_next      = q_cnt_reg;
        flush_next      = flush_reg;
        win_next        = win_reg;
        held_next       = held_reg;
        in_quote_next   = in_quote_reg;
        quote_seen_next = quote_seen_reg;
        esc_held_next   = esc_held_reg;
        null_match_next = null_match_reg;
        raw_len_next    = raw_len_reg;
        discard_next    = discard_reg;
        err_next        = err_reg;
        field_next      = field_reg;
        res_cnt_next    = res_cnt_reg;
        emit_v          = 1'b0;
        emit_r          = '0;

        unique case (cmd.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                res_cnt_next = '0;
                if (in_eol)
                begin
                    for (int j = 0; j < QDEPTH; j++)
                        q_next[j] = win_reg[j];
                    q_cnt_next = QCW'(held_reg);
                    held_next  = '0;
                    flush_next = 1'b1;
                end
                else
                begin
                    q_next[0]  = in_byte;
                    q_cnt_next = QCW'(1);
                    flush_next = 1'b0;
                end
            end
            OP_STEP:
            begin
                if (in_quote_reg)
                begin
                    if (esc_held_reg)
                    begin
                        esc_held_next = 1'b0;
                        if (x == cfg.escape_char || x == cfg.quote_char)
                        begin
                            emit_v     = 1'b1;
                            emit_r     = mk_data(x, field_reg[9:0]);
                            q_next     = q_pop;
                            q_cnt_next = q_cnt_reg - QCW'(1);
                        end
                        else if (cfg.escape_char == cfg.quote_char)
                            in_quote_next = 1'b0;   // byte is rescanned unquoted
                        else
                        begin
                            // escape goes out now, the byte itself on the next step
                            emit_v = 1'b1;
                            emit_r = mk_data(cfg.escape_char, field_reg[9:0]);
                        end
                    end
                    else
                    begin
                        q_next     = q_pop;
                        q_cnt_next = q_cnt_reg - QCW'(1);
                        if (x == cfg.escape_char)
                            esc_held_next = 1'b1;
                        else if (x == cfg.quote_char)
                            in_quote_next = 1'b0;
                        else
                        begin
                            emit_v = 1'b1;
                            emit_r = mk_data(x, field_reg[9:0]);
                        end
                    end
                end
                else if (!flush_reg && dmatch && hn == DCW'(cfg.delim_len))
                begin
                    q_next              = q_pop;
                    q_cnt_next          = q_cnt_reg - QCW'(1);
                    emit_v              = 1'b1;
                    emit_r.field_end    = 1'b1;
                    emit_r.field_is_null = null_now;
                    emit_r.field_index  = field_reg[9:0];
                    field_next          = field_inc;
                    quote_seen_next     = 1'b0;
                    esc_held_next       = 1'b0;
                    null_match_next     = 1'b1;
                    raw_len_next        = 4'd0;
                    held_next           = '0;
                    if (field_inc >= cfg.field_limit)
                    begin
                        discard_next = 1'b1;
                        err_next     = cfg.ignore_extra ? STATUS_OK : STATUS_EXTRA;
                    end
                end
                else if (!flush_reg && dmatch)
                begin
                    q_next     = q_pop;
                    q_cnt_next = q_cnt_reg - QCW'(1);
                    win_next   = win_new;
                    held_next  = hn[DW-1:0];
                end
                else
                begin
                    if (flush_reg)
                    begin
                        q_next     = q_pop;
                        q_cnt_next = q_cnt_reg - QCW'(1);
                    end
                    else
                    begin
                        q_next     = q_rb;
                        q_cnt_next = QCW'(held_reg) + q_cnt_reg - QCW'(1);
                        held_next  = '0;
                    end
                    // ordinary character outside quotes
                    if (pr == cfg.quote_char)
                    begin
                        in_quote_next   = 1'b1;
                        quote_seen_next = 1'b1;
                    end
                    else
                    begin
                        emit_v = 1'b1;
                        emit_r = mk_data(pr, field_reg[9:0]);
                        if (!keep)
                            null_match_next = 1'b0;
                        if (raw_len_reg < 4'(MAX_NULL_LEN + 1))
                            raw_len_next = raw_len_reg + 4'd1;
                    end
                end
            end
            OP_ESC:
            begin
                if (esc_held_reg)
                begin
                    esc_held_next = 1'b0;
                    if (cfg.escape_char == cfg.quote_char)
                        in_quote_next = 1'b0;
                    else
                    begin
                        emit_v = 1'b1;
                        emit_r = mk_data(cfg.escape_char, field_reg[9:0]);
                    end
                end
            end
            OP_LINE:
            begin
                emit_v             = 1'b1;
                emit_r.line_end    = 1'b1;
                emit_r.field_index = field_reg[9:0];
                if (discard_reg)
                begin
                    emit_r.field_count = field_reg;
                    emit_r.status      = err_reg;
                end
                else if (in_quote_reg)
                begin
                    emit_r.field_count = field_reg;
                    emit_r.status      = STATUS_UNTERM;
                end
                else
                begin
                    emit_r.field_end     = 1'b1;
                    emit_r.field_is_null = null_now;
                    emit_r.field_count   = field_inc;
                    emit_r.status        = STATUS_OK;
                end
                quote_seen_next = 1'b0;
                esc_held_next   = 1'b0;
                null_match_next = 1'b1;
                raw_len_next    = 4'd0;
                held_next       = '0;
                in_quote_next   = 1'b0;
                field_next      = 11'd0;
                discard_next    = 1'b0;
                err_next        = STATUS_OK;
                flush_next      = 1'b0;
            end
            OP_DONE: ;
            default: ;
        endcase
    end

    // result holding register keeps one word back so the last one can be marked
    always_comb
    begin
        emit_take = emit_v && (res_cnt_reg < RCW'(MAX_RESULTS));
        out_free  = !out_v_reg || out_ready;
        stall     = (emit_take || cmd.op == OP_DONE) && pend_v_reg && !out_free;
        out_load  = !stall && pend_v_reg && (emit_take || cmd.op == OP_DONE);

        out_next      = pend_reg;
        out_next.last = (cmd.op == OP_DONE);
        out_v_next    = out_load || (out_v_reg && !out_ready);

        pend_next   = emit_r;
        pend_v_next = pend_v_reg;
        if (!stall && emit_take)
            pend_v_next = 1'b1;
        else if (!stall && cmd.op == OP_DONE)
            pend_v_next = 1'b0;

        stat.q_empty    = (q_cnt_reg == '0);
        stat.discarding = discard_reg;
        stat.flush      = flush_reg;
        stat.stall      = stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg      <= '0;
            flush_reg      <= 1'b0;
            held_reg       <= '0;
            in_quote_reg   <= 1'b0;
            quote_seen_reg <= 1'b0;
            esc_held_reg   <= 1'b0;
            null_match_reg <= 1'b1;
            raw_len_reg    <= 4'd0;
            discard_reg    <= 1'b0;
            err_reg        <= STATUS_OK;
            field_reg      <= 11'd0;
            res_cnt_reg    <= '0;
            pend_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            pend_v_reg <= pend_v_next;
            if (!stall)
            begin
                q_cnt_reg      <= q_cnt_next;
                flush_reg      <= flush_next;
                held_reg       <= held_next;
                in_quote_reg   <= in_quote_next;
                quote_seen_reg <= quote_seen_next;
                esc_held_reg   <= esc_held_next;
                null_match_reg <= null_match_next;
                raw_len_reg    <= raw_len_next;
                discard_reg    <= discard_next;
                err_reg        <= err_next;
                field_reg      <= field_next;
                res_cnt_reg    <= emit_take ? res_cnt_reg + RCW'(1) : res_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            q_reg   <= q_next;
            win_reg <= win_next;
            if (emit_take)
                pend_reg <= pend_next;
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign out_valid = out_v_reg;
    assign out_res   = out_reg;

endmodule

// ===== sv/csv_field_splitter.sv =====
// top level of the csv field splitter: config registers, sequencer and datapath
// depends on csv_pkg, csv_in_if, csv_out_if, csv_cfg, csv_ctrl, csv_dp
//
// Splits one CSV line, fed as raw bytes followed by an end-of-line word, into decoded
// field bytes, field ends and a closing line word; at most eight result words per input
// word, the final one carrying last. One input word is handled at a time: a data byte
// is accepted, scanned, checked for an empty queue and handed over, with a further scan
// step per byte replayed after an escape or a broken partial delimiter; an end-of-line
// word also scans its held delimiter bytes, then passes escape, line and done. The
// sequencer walks its replay queue one byte per cycle through the single scan step while
// the output does not stall. Configuration is written through cfg_we, cfg_index, cfg_data
// while no line word is in flight; the user must ensure it, the block does not enforce it.
module csv_field_splitter (
    input  logic        clk,
    input  logic        rst_n,
    csv_in_if.sink      byte_in,
    csv_out_if.source   field_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import csv_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  res;
    logic     in_ready;

    csv_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    csv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_eol   (byte_in.end_of_line),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .in_byte   (byte_in.in_byte),
        .in_eol    (byte_in.end_of_line),
        .stat      (stat),
        .out_valid (field_out.valid),
        .out_ready (field_out.ready),
        .out_res   (res)
    );

    assign byte_in.ready           = in_ready;
    assign field_out.out_byte      = res.out_byte;
    assign field_out.byte_valid    = res.byte_valid;
    assign field_out.field_end     = res.field_end;
    assign field_out.field_is_null = res.field_is_null;
    assign field_out.field_index   = res.field_index;
    assign field_out.line_end      = res.line_end;
    assign field_out.field_count   = res.field_count;
    assign field_out.status        = res.status;
    assign field_out.last          = res.last;

endmodule
